FILE: rtl/tsg_pkg.sv
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared types, codes and constants of the two-sided Gaussian shape core.
// ----------------------------------------------------------------------------
package tsg_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // ln 2 as unsigned Q.32
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  // z saturation point, 64.0 in Q.32
  localparam logic [38:0] Z_CAP = 39'h40_0000_0000;

  // region codes
  localparam logic [1:0] REG_LEFT = 2'd0;
  localparam logic [1:0] REG_CORE = 2'd1;
  localparam logic [1:0] REG_TAIL = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_MEAN        = 2'd0;
  localparam logic [1:0] CFG_LEFT_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_RIGHT_WIDTH = 2'd2;
  localparam logic [1:0] CFG_TAIL_SLOPE  = 2'd3;

  typedef struct packed {
    logic signed [31:0] mean;
    logic [30:0]        left_width;
    logic [30:0]        right_width;
    logic signed [31:0] tail_slope;
  } cfg_t;

  // one classified word handed from the front to the back
  typedef struct packed {
    logic [1:0]  region;
    logic [31:0] span;    // distance whose square is the Gaussian numerator
    logic [62:0] den;     // 2 * width^2
    logic [31:0] excess;  // x - crossover, zero outside the tail
  } job_t;

endpackage

FILE: rtl/tsg_front.sv
// ----------------------------------------------------------------------------
// tsg_front
// Accepts positions, finds the crossover and classifies each word.
// ----------------------------------------------------------------------------
module tsg_front
  import tsg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] position,
  output logic        out_valid,
  input  logic        out_ready,
  output job_t        job
);

  logic        en;
  logic        v1, v2, v3, v4;
  logic [31:0] x1, x2, x3;
  logic [61:0] rsq2, rsq3, lsq2, lsq3;
  logic [62:0] lo3;
  logic [60:0] hm3;
  logic [30:0] sl, sr, s31;

  assign en        = !v4 || out_ready;
  assign in_ready  = en;
  assign out_valid = v4;

  // zero width reads as one LSB
  assign sl  = (cfg.left_width == '0) ? 31'd1 : cfg.left_width;
  assign sr  = (cfg.right_width == '0) ? 31'd1 : cfg.right_width;
  assign s31 = cfg.tail_slope[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1   <= position;
      x2   <= x1;
      rsq2 <= 62'(sr) * 62'(sr);
      lsq2 <= 62'(sl) * 62'(sl);
      x3   <= x2;
      rsq3 <= rsq2;
      lsq3 <= lsq2;
      lo3  <= 63'(s31) * 63'(rsq2[31:0]);
      hm3  <= 61'(s31) * 61'(rsq2[61:32]);
    end
  end

  // classification, feeds the output register
  logic signed [32:0] diff, pmax_m;
  logic [63:0]        hi;
  logic               x_lt_m, xc_sat, in_tail;
  logic signed [31:0] xc;
  logic [31:0]        d, c, e;
  job_t               job_next;

  always_comb begin
    diff    = 33'($signed(x3)) - 33'(cfg.mean);
    x_lt_m  = diff[32];
    d       = x_lt_m ? 32'(-diff) : diff[31:0];
    hi      = {3'b0, hm3} + {33'b0, lo3[62:32]};
    pmax_m  = 33'sh0_7FFF_FFFF - 33'(cfg.mean);
    xc_sat  = (hi > 64'h1_0000_0000) || (hi > 64'(pmax_m));
    xc      = xc_sat ? 32'sh7FFF_FFFF : (cfg.mean + $signed(hi[31:0]));
    in_tail = !x_lt_m && !cfg.tail_slope[31] && ($signed(x3) >= xc);
    c       = 32'(xc - cfg.mean);
    e       = 32'($signed(x3) - xc);
    job_next.region = x_lt_m ? REG_LEFT : (in_tail ? REG_TAIL : REG_CORE);
    job_next.span   = in_tail ? c : d;
    job_next.den    = x_lt_m ? {lsq3, 1'b0} : {rsq3, 1'b0};
    job_next.excess = in_tail ? e : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      job <= job_next;
    end
  end

endmodule

FILE: rtl/tsg_queue.sv
// ----------------------------------------------------------------------------
// tsg_queue
// Short FIFO between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module tsg_queue
  import tsg_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  job_t in_job,
  output logic out_valid,
  input  logic out_ready,
  output job_t out_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          push, pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_job;
    end
  end

endmodule

FILE: rtl/tsg_exp.sv
// ----------------------------------------------------------------------------
// tsg_exp
// Pipelined exp(-z) from k and r: twelve Horner terms, two stages each.
// ----------------------------------------------------------------------------
module tsg_exp
  import tsg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] r,
  input  logic [4:0]  k,
  input  logic        big,
  input  logic [1:0]  region_in,
  output logic        out_valid,
  output logic [31:0] shape_value,
  output logic [1:0]  region_out
);

  localparam int TERMS = 12;
  localparam int NS    = 2 * TERMS;

  logic        sv  [NS+1];
  logic [31:0] sr  [NS+1];
  logic [4:0]  sk  [NS+1];
  logic        sb  [NS+1];
  logic [1:0]  sg  [NS+1];
  logic [32:0] st  [NS+1];
  logic [31:0] su  [NS+1];

  assign sv[0] = in_valid;
  assign sr[0] = r;
  assign sk[0] = k;
  assign sb[0] = big;
  assign sg[0] = region_in;
  assign st[0] = 33'h1_0000_0000;
  assign su[0] = 32'd0;

  for (genvar i = 0; i < NS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i+1] <= 1'b0;
      end else if (en) begin
        sv[i+1] <= sv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sr[i+1] <= sr[i];
        sk[i+1] <= sk[i];
        sb[i+1] <= sb[i];
        sg[i+1] <= sg[i];
      end
    end

    if ((i % 2) == 0) begin : g_mul
      // u = floor(r * t / 2^32)
      logic [64:0] p;
      assign p = 65'(sr[i]) * 65'(st[i]);
      always_ff @(posedge clk) begin
        if (en) begin
          su[i+1] <= p[63:32];
          st[i+1] <= st[i];
        end
      end
    end else begin : g_div
      // t = 2^32 - floor(u / n), n by reciprocal, exact for 32-bit u
      localparam int N = TERMS - i / 2;
      localparam logic [36:0] RECIP = 37'(((64'd1 << 36) + 64'(N) - 64'd1) / 64'(N));
      logic [68:0] q;
      assign q = 69'(su[i]) * 69'(RECIP);
      always_ff @(posedge clk) begin
        if (en) begin
          st[i+1] <= 33'h1_0000_0000 - {1'b0, q[67:36]};
          su[i+1] <= su[i];
        end
      end
    end
  end

  logic [33:0] rnd_sum;
  logic [33:0] scaled;
  assign rnd_sum = {1'b0, st[NS]} + (34'd1 << sk[NS]);
  assign scaled  = rnd_sum >> (6'(sk[NS]) + 6'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      shape_value <= sb[NS] ? 32'd0 : scaled[31:0];
      region_out  <= sg[NS];
    end
  end

endmodule

FILE: rtl/tsg_back.sv
// ----------------------------------------------------------------------------
// tsg_back
// Squares, long division to Q.32, tail term, range reduction and exp.
// ----------------------------------------------------------------------------
module tsg_back
  import tsg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] tail_slope,
  input  logic               in_valid,
  output logic               in_ready,
  input  job_t               job,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        shape_value,
  output logic [1:0]         region
);

  localparam int QB = 39;  // quotient bits: 7 integer, 32 fraction

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: squares and tail product
  logic        v1;
  logic [63:0] num1;
  logic [62:0] tp1, den1;
  logic [1:0]  g1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num1 <= 64'(job.span) * 64'(job.span);
      tp1  <= 63'(tail_slope[30:0]) * 63'(job.excess);
      den1 <= job.den;
      g1   <= job.region;
    end
  end

  // divider stages; stage 0 holds the saturation check and initial remainder
  logic        dv [QB+1];
  logic [63:0] dr [QB+1];
  logic [6:0]  dn [QB+1];
  logic [62:0] dd [QB+1];
  logic [QB-1:0] dq [QB+1];
  logic        ds [QB+1];
  logic [38:0] dt [QB+1];
  logic [1:0]  dg [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds[0] <= ({6'b0, num1} >= {1'b0, den1, 6'b0});
      dr[0] <= {7'b0, num1[63:7]};
      dn[0] <= num1[6:0];
      dd[0] <= den1;
      dq[0] <= '0;
      dt[0] <= (tp1 > 63'(Z_CAP)) ? Z_CAP : tp1[38:0];
      dg[0] <= g1;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int B = QB - 1 - j;
    logic        nb;
    logic [63:0] rs;
    logic        ge;
    if (B >= 32) begin : g_numbit
      assign nb = dn[j][B-32];
    end else begin : g_zerobit
      assign nb = 1'b0;
    end
    assign rs = {dr[j][62:0], nb};
    assign ge = (rs >= {1'b0, dd[j]});

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else if (en) begin
        dv[j+1] <= dv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dr[j+1]    <= ge ? (rs - {1'b0, dd[j]}) : rs;
        dq[j+1]    <= dq[j] | (ge ? (QB'(1) << B) : '0);
        dn[j+1]    <= dn[j];
        dd[j+1]    <= dd[j];
        ds[j+1]    <= ds[j];
        dt[j+1]    <= dt[j];
        dg[j+1]    <= dg[j];
      end
    end
  end

  // z = ratio + tail
  logic        zv;
  logic [39:0] z;
  logic [1:0]  zg;

  always_ff @(posedge clk) begin
    if (rst) begin
      zv <= 1'b0;
    end else if (en) begin
      zv <= dv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z  <= {1'b0, (ds[QB] ? Z_CAP : dq[QB])} + {1'b0, dt[QB]};
      zg <= dg[QB];
    end
  end

  // k = floor(z / ln2), r = z - k*ln2, five restoring steps
  logic        kv;
  logic [4:0]  kk, k_next;
  logic [31:0] kr;
  logic        kb;
  logic [1:0]  kg;
  logic [39:0] rr;

  always_comb begin
    rr     = z;
    k_next = '0;
    for (int i = 4; i >= 0; i--) begin
      if (rr >= (40'(LN2_Q32) << i)) begin
        rr        = rr - (40'(LN2_Q32) << i);
        k_next[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kv <= 1'b0;
    end else if (en) begin
      kv <= zv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kk <= k_next;
      kr <= rr[31:0];
      kb <= (z >= (40'(LN2_Q32) << 5));
      kg <= zg;
    end
  end

  tsg_exp u_exp (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (kv),
    .r           (kr),
    .k           (kk),
    .big         (kb),
    .region_in   (kg),
    .out_valid   (out_valid),
    .shape_value (shape_value),
    .region_out  (region)
  );

endmodule

FILE: rtl/two_sided_gaussian_exp_tail_core.sv
// ----------------------------------------------------------------------------
// two_sided_gaussian_exp_tail_core
// Asymmetric Gaussian shape with an exponential right tail, streaming.
// ----------------------------------------------------------------------------
// Takes one Q16.16 position per word and returns exp(-z) as unsigned Q1.31
// plus the region (left Gaussian, right core, tail) in tuser. Fully
// pipelined: one word per clock sustained while m_tready stays high. A word
// passes the front that finds the crossover and classifies, the queue and
// the back, with its one bit per stage long division and the two-stage
// Horner terms of exp. The queue lets the front keep accepting while the
// back is held by m_tready, until the queue fills.
// Configuration writes take effect at once and must only be made while no
// word is in flight.
// ----------------------------------------------------------------------------
module two_sided_gaussian_exp_tail_core
  import tsg_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [31:0] position
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [31:0] shape_value
  output logic [1:0]  m_tuser     // [1:0] region
);

  cfg_t cfg;

  // config registers; an index always hits one of the four
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mean        <= 32'sd0;
      cfg.left_width  <= 31'd65536;
      cfg.right_width <= 31'd65536;
      cfg.tail_slope  <= 32'sd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MEAN:        cfg.mean        <= $signed(cfg_data);
        CFG_LEFT_WIDTH:  cfg.left_width  <= cfg_data[30:0];
        CFG_RIGHT_WIDTH: cfg.right_width <= cfg_data[30:0];
        CFG_TAIL_SLOPE:  cfg.tail_slope  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // front -> queue -> back
  logic fe_valid, q_ready, q_valid, be_ready;
  job_t fe_job, q_job;

  tsg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .position  (s_tdata),
    .out_valid (fe_valid),
    .out_ready (q_ready),
    .job       (fe_job)
  );

  tsg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fe_valid),
    .in_ready  (q_ready),
    .in_job    (fe_job),
    .out_valid (q_valid),
    .out_ready (be_ready),
    .out_job   (q_job)
  );

  tsg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .tail_slope  (cfg.tail_slope),
    .in_valid    (q_valid),
    .in_ready    (be_ready),
    .job         (q_job),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .shape_value (m_tdata),
    .region      (m_tuser)
  );

  // the front only stalls when its last word cannot enter the queue
  a_front_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (fe_valid && !q_ready))
    else $error("front stalled without a full queue");

  a_region_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == REG_LEFT || m_tuser == REG_CORE || m_tuser == REG_TAIL))
    else $error("bad region code on output");

  a_value_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata <= 32'h8000_0000))
    else $error("shape value above 1.0");

  // the queue drains into the back whenever the back moves
  a_queue_drain: assert property (@(posedge clk) disable iff (rst)
    (q_valid && (!m_tvalid || m_tready)) |-> be_ready)
    else $error("back refused a word while advancing");

endmodule

FILE: bench/tb_two_sided_gaussian_exp_tail_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_sided_gaussian_exp_tail_core
// Self-checking bench for the asymmetric Gaussian / exponential tail core.
// ----------------------------------------------------------------------------
// A directed table runs first: reset settings, extreme positions, zero and
// negative slope, zero width and a saturated crossover. Random phases
// follow, each with its own register settings, positions mostly clustered
// around the mean. Every accepted position is run through a local bit-exact
// shape model. The expected value and region are queued and compared in
// order with each output word. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_two_sided_gaussian_exp_tail_core;
  import tsg_pkg::*;

  localparam int               IDLE_LIMIT = 3000;
  localparam int               SETTLE     = 100;   // margin above the pipeline depth
  localparam longint           POS_MAX    = 64'sd2147483647;
  localparam longint unsigned  ONE_Q      = 64'd1 << 32;
  localparam longint unsigned  ZSAT       = 64'd64 << 32;
  localparam logic [31:0]      UNITY      = 32'h8000_0000;   // 1.0 in Q1.31

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  index;   // register index for ROW_CFG
    logic [31:0] data;    // register value or position
    bit          fixed;   // value and region typed in below
    logic [31:0] value;
    logic [1:0]  region;
  } row_t;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  region;
  } shape_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;    // [31:0] position
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [31:0] shape_value
  logic [1:0]  m_tuser;         // [1:0] region

  // local copy of the registers
  logic signed [31:0] mean_r  = 32'sd0;
  logic [30:0]        left_r  = 31'd65536;
  logic [30:0]        right_r = 31'd65536;
  logic signed [31:0] slope_r = 32'sd65536;

  // typed-in expectation of the word currently offered
  bit          fixed_now = 1'b0;
  shape_t      fixed_shape = '{32'd0, 2'd0};

  shape_t      shape_q[$];
  row_t        rows[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;    // no-idle stretch on both sides

  two_sided_gaussian_exp_tail_core dut (.*);

  always #5 clk = ~clk;

  // ---- shape model --------------------------------------------------------

  // floor(num * 2^32 / den), saturated at 64.0
  function automatic longint unsigned q32_ratio(longint unsigned num,
                                                longint unsigned den);
    longint unsigned ip, rem, frac;
    ip   = num / den;
    rem  = num % den;
    frac = 0;
    if (ip >= 64) return ZSAT;
    for (int i = 0; i < 32; i++) begin
      rem  = rem << 1;
      frac = frac << 1;
      if (rem >= den) begin
        rem  = rem - den;
        frac = frac | 64'd1;
      end
    end
    return (ip << 32) | frac;
  endfunction

  // exp(-z), z in Q.32, result Q1.31
  function automatic logic [31:0] exp_neg_q31(longint unsigned z);
    longint unsigned k, r, t;
    k = z / longint'(LN2_Q32);
    if (k >= 32) return 32'd0;
    r = z - k * longint'(LN2_Q32);
    t = ONE_Q;
    for (int n = 12; n >= 1; n--)
      t = ONE_Q - (((r * t) / longint'(n)) >> 32);
    return 32'((t + (64'd1 << k)) >> (k + 1));
  endfunction

  function automatic shape_t eval_shape(logic signed [31:0] pos);
    shape_t          res;
    longint          xs, m, xc;
    longint unsigned sl, sr, su, d, z, p, lo, hi, c, e, tail;
    bit              core;
    xs   = pos;
    m    = mean_r;
    su   = longint'(slope_r);
    sl   = (left_r == 0) ? 64'd1 : 64'(left_r);
    sr   = (right_r == 0) ? 64'd1 : 64'(right_r);
    xc   = 0;
    core = 1'b1;
    if (xs < m) begin
      d = longint'(m - xs);
      z = q32_ratio(d * d, 2 * sl * sl);
      res.region = REG_LEFT;
    end else begin
      d = longint'(xs - m);
      if (slope_r >= 0) begin
        // crossover = mean + slope * right_width^2, Q16.16, saturated
        p  = sr * sr;
        lo = su * (p & 64'hFFFF_FFFF);
        hi = su * (p >> 32) + (lo >> 32);
        if (hi > ONE_Q || longint'(hi) > POS_MAX - m) xc = POS_MAX;
        else xc = m + longint'(hi);
        core = xs < xc;
      end
      if (core) begin
        z = q32_ratio(d * d, 2 * sr * sr);
        res.region = REG_CORE;
      end else begin
        c    = longint'(xc - m);
        e    = longint'(xs - xc);
        tail = su * e;
        if (tail > ZSAT) tail = ZSAT;
        z = q32_ratio(c * c, 2 * sr * sr) + tail;
        res.region = REG_TAIL;
      end
    end
    res.value = exp_neg_q31(z);
    return res;
  endfunction

  // ---- drivers --------------------------------------------------------------

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_MEAN:        mean_r  = val;
      CFG_LEFT_WIDTH:  left_r  = val[30:0];
      CFG_RIGHT_WIDTH: right_r = val[30:0];
      CFG_TAIL_SLOPE:  slope_r = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // stop offering, wait until every expected word is back and the pipe emptied
  task automatic drain();
    s_tvalid <= 1'b0;
    while (shape_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_word(logic [31:0] pos, bit fx, shape_t fs);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid    <= 1'b1;
    s_tdata     <= pos;
    fixed_now   <= fx;
    fixed_shape <= fs;
    do @(posedge clk); while (!s_tready);
  endtask

  // position near the mean, or anywhere
  function automatic logic [31:0] pick_position();
    longint w, off, p;
    if ($urandom_range(0, 4) == 0) return $urandom;
    w   = $urandom_range(0, 1) ? longint'(left_r) : longint'(right_r);
    if (w == 0) w = 1;
    off = ((longint'($urandom_range(0, 16000)) - 8000) * w) / 1000;
    p   = longint'(mean_r) + off;
    if (p > POS_MAX) p = POS_MAX;
    if (p < -POS_MAX - 1) p = -POS_MAX - 1;
    return 32'(p);
  endfunction

  function automatic logic [31:0] pick_width();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;   // top bit dropped, max width
      default: return $urandom_range(256, 1 << 22);
    endcase
  endfunction

  function automatic logic [31:0] pick_slope();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'd0;
      2: return 32'h7FFF_FFFF;
      3: return -$urandom_range(1, 1 << 20);
      default: return $urandom_range(1, 4 << 16);
    endcase
  endfunction

  function automatic logic [31:0] pick_mean();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  // ---- receive side: stall per word ---------------------------------------
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // ---- monitor: predict on input, compare on output -----------------------
  always @(posedge clk) begin
    shape_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        want = eval_shape(s_tdata);
        // typed-in rows must agree with the model too
        if (fixed_now && (want.value != fixed_shape.value ||
                          want.region != fixed_shape.region)) begin
          report("typed value", want.value, fixed_shape.value);
          want = fixed_shape;
        end
        shape_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (shape_q.size() == 0) begin
          report("unexpected word", m_tdata, 32'd0);
        end else begin
          want = shape_q.pop_front();
          if (m_tdata !== want.value) report("shape_value", m_tdata, want.value);
          if (m_tuser !== want.region) report("region", m_tuser, want.region);
        end
      end
    end
  end

  // ---- watchdog: cycles without any transfer ------------------------------
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL two_sided_gaussian_exp_tail_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---- stimulus ------------------------------------------------------------
  initial begin
    shape_t none;
    none = '{32'd0, 2'd0};
    // directed table; fixed rows carry values read straight off the formula
    rows.push_back('{ROW_WORD, 0, 32'd0,        1, UNITY, REG_CORE});  // peak
    rows.push_back('{ROW_WORD, 0, 32'h8000_0000, 1, 32'd0, REG_LEFT});
    rows.push_back('{ROW_WORD, 0, 32'h7FFF_FFFF, 1, 32'd0, REG_TAIL});
    rows.push_back('{ROW_WORD, 0, 32'd65536,    0, 32'd0, REG_TAIL});  // at crossover
    rows.push_back('{ROW_WORD, 0, 32'hFFFF_0000, 0, 32'd0, REG_LEFT});
    rows.push_back('{ROW_WORD, 0, 32'd65535,    0, 32'd0, REG_CORE});
    // zero slope: tail starts at the mean and stays at 1.0
    rows.push_back('{ROW_CFG, CFG_TAIL_SLOPE, 32'd0, 0, 32'd0, REG_LEFT});
    rows.push_back('{ROW_WORD, 0, 32'd0,        1, UNITY, REG_TAIL});
    rows.push_back('{ROW_WORD, 0, 32'd1000,     1, UNITY, REG_TAIL});
    rows.push_back('{ROW_WORD, 0, 32'hFFFF_FFFF, 0, 32'd0, REG_LEFT});
    // negative slope: no tail at all
    rows.push_back('{ROW_CFG, CFG_TAIL_SLOPE, 32'hFFFF_FFFF, 0, 32'd0, REG_LEFT});
    rows.push_back('{ROW_WORD, 0, 32'h7FFF_FFFF, 1, 32'd0, REG_CORE});
    rows.push_back('{ROW_WORD, 0, 32'd0,        1, UNITY, REG_CORE});
    // zero left width acts as one LSB
    rows.push_back('{ROW_CFG, CFG_LEFT_WIDTH, 32'd0, 0, 32'd0, REG_LEFT});
    rows.push_back('{ROW_WORD, 0, 32'hFFFF_FFFF, 0, 32'd0, REG_LEFT});
    rows.push_back('{ROW_WORD, 0, 32'hFFFF_FFFE, 0, 32'd0, REG_LEFT});
    // widest sigma, steepest slope: crossover saturates
    rows.push_back('{ROW_CFG, CFG_RIGHT_WIDTH, 32'hFFFF_FFFF, 0, 32'd0, REG_LEFT});
    rows.push_back('{ROW_CFG, CFG_TAIL_SLOPE, 32'h7FFF_FFFF, 0, 32'd0, REG_LEFT});
    rows.push_back('{ROW_WORD, 0, 32'h7FFF_FFFF, 0, 32'd0, REG_TAIL});
    rows.push_back('{ROW_WORD, 0, 32'h4000_0000, 0, 32'd0, REG_CORE});
    // mean at the top: crossover clamps onto it
    rows.push_back('{ROW_CFG, CFG_MEAN, 32'h7FFF_FFFF, 0, 32'd0, REG_LEFT});
    rows.push_back('{ROW_CFG, CFG_LEFT_WIDTH, 32'hFFFF_FFFF, 0, 32'd0, REG_LEFT});
    rows.push_back('{ROW_WORD, 0, 32'h7FFF_FFFF, 1, UNITY, REG_TAIL});
    rows.push_back('{ROW_WORD, 0, 32'h8000_0000, 0, 32'd0, REG_LEFT});
    // mean at the bottom: crossover still saturates high, so the peak is core
    rows.push_back('{ROW_CFG, CFG_MEAN, 32'h8000_0000, 0, 32'd0, REG_LEFT});
    rows.push_back('{ROW_WORD, 0, 32'h8000_0000, 1, UNITY, REG_CORE});

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(rows[i].index, rows[i].data);
      end else begin
        send_word(rows[i].data, rows[i].fixed, '{rows[i].value, rows[i].region});
      end
    end

    // random phases, each with fresh settings
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      write_reg(CFG_MEAN, pick_mean());
      write_reg(CFG_LEFT_WIDTH, pick_width());
      write_reg(CFG_RIGHT_WIDTH, pick_width());
      write_reg(CFG_TAIL_SLOPE, pick_slope());
      for (int n = 0; n < 175; n++) begin
        if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
        send_word(pick_position(), 1'b0, none);
      end
      quiet = 1'b0;
    end

    drain();
    if (errors == 0) begin
      $display("PASS two_sided_gaussian_exp_tail_core");
    end else begin
      $display("FAIL two_sided_gaussian_exp_tail_core");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tsg_pkg.sv
rtl/tsg_front.sv
rtl/tsg_queue.sv
rtl/tsg_exp.sv
rtl/tsg_back.sv
rtl/two_sided_gaussian_exp_tail_core.sv
bench/tb_two_sided_gaussian_exp_tail_core.sv
